// ----- rtl/axis_cumulative_sum_core_assert.svh -----
// Assertion macros shared by the cumulative sum core.
`ifndef AXIS_CUMULATIVE_SUM_CORE_ASSERT_SVH
`define AXIS_CUMULATIVE_SUM_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ACS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ACS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/acs_pkg.sv -----
package acs_pkg;

    localparam int MAX_INNER   = 1024;
    localparam int INDEX_WIDTH = 32;

    localparam int DATA_W      = 32;
    localparam int IN_IDX_W    = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int ROW_W       = 24;
    localparam int COUNT_W     = 25;
    localparam int INNER_CNT_W = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_LENGTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCLUSIVE_MODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_TYPE      = 3'd5;

    typedef enum logic [1:0] {
        ELEM_INT32 = 2'd0,
        ELEM_INT8  = 2'd1,
        ELEM_UINT8 = 2'd2
    } elem_type_t;

    // Clamped configuration, counts held as their last position.
    typedef struct packed {
        logic [IN_IDX_W-1:0]    in_last;
        logic [ROW_W-1:0]       row_last;
        logic [ROW_W-1:0]       out_last;
        logic                   exclusive_mode;
        logic                   reverse_mode;
        elem_type_t             elem_type;
        logic [INDEX_WIDTH-1:0] slab_size;
    } cfg_t;

    // Scan position of the item at the input.
    typedef struct packed {
        logic [IN_IDX_W-1:0]    ip;
        logic [ROW_W-1:0]       row;
        logic                   first_row;
        logic                   last;
        logic [INDEX_WIDTH-1:0] base_ip;
    } scan_t;

    function automatic logic [DATA_W-1:0] fit_type(logic [DATA_W-1:0] x, elem_type_t t);
        logic [DATA_W-1:0] r;
        case (t)
            ELEM_INT8:  r = {{(DATA_W-8){x[7]}}, x[7:0]};
            ELEM_UINT8: r = {{(DATA_W-8){1'b0}}, x[7:0]};
            default:    r = x;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/acs_stream_if.sv -----
interface acs_in_if import acs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface acs_out_if import acs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sum_out;
    logic [31:0]              dest_index;
    logic                     last;

    modport source (output valid, output sum_out, output dest_index, output last, input ready);
    modport sink   (input valid, input sum_out, input dest_index, input last, output ready);
endinterface

// ----- rtl/acs_cfg.sv -----
module acs_cfg import acs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    localparam int PROD_W = COUNT_W + IN_IDX_W + 1;

    logic [IN_IDX_W-1:0]    in_last_reg, in_last_next;
    logic [ROW_W-1:0]       row_last_reg, row_last_next;
    logic [ROW_W-1:0]       out_last_reg, out_last_next;
    logic                   excl_reg, excl_next;
    logic                   rev_reg, rev_next;
    elem_type_t             etype_reg, etype_next;
    logic [INDEX_WIDTH-1:0] slab_size_reg, slab_size_next;

    logic [INNER_CNT_W-1:0] inner_wr;
    logic [COUNT_W-1:0]     row_cnt;
    logic [IN_IDX_W:0]      in_cnt;
    logic [PROD_W-1:0]      slab_prod;

    function automatic logic [ROW_W-1:0] clamp_axis(logic [COUNT_W-1:0] v);
        logic [ROW_W-1:0] r;
        if (v == '0)
            r = '0;
        else if (v[COUNT_W-1])
            r = '1;
        else
            r = v[ROW_W-1:0] - 1'b1;
        return r;
    endfunction

    assign inner_wr = cfg_wdata[INNER_CNT_W-1:0];

    always_comb
    begin
        in_last_next  = in_last_reg;
        row_last_next = row_last_reg;
        out_last_next = out_last_reg;
        excl_next     = excl_reg;
        rev_next      = rev_reg;
        etype_next    = etype_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_OUTER_COUNT: out_last_next = clamp_axis(cfg_wdata[COUNT_W-1:0]);
                CFG_AXIS_LENGTH: row_last_next = clamp_axis(cfg_wdata[COUNT_W-1:0]);
                CFG_INNER_COUNT:
                begin
                    if (inner_wr == '0)
                        in_last_next = '0;
                    else if (32'(inner_wr) > 32'(MAX_INNER))
                        in_last_next = IN_IDX_W'(MAX_INNER - 1);
                    else
                        in_last_next = IN_IDX_W'(inner_wr - 1'b1);
                end
                CFG_EXCLUSIVE_MODE: excl_next  = cfg_wdata[0];
                CFG_REVERSE_MODE:   rev_next   = cfg_wdata[0];
                CFG_ELEM_TYPE:      etype_next = elem_type_t'(cfg_wdata[1:0]);
                default: ;
            endcase
        end
        // Slab size tracks the new counts at the same edge as the write.
        row_cnt        = {1'b0, row_last_next} + 1'b1;
        in_cnt         = {1'b0, in_last_next} + 1'b1;
        slab_prod      = {{(IN_IDX_W+1){1'b0}}, row_cnt} * {{COUNT_W{1'b0}}, in_cnt};
        slab_size_next = INDEX_WIDTH'(slab_prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_last_reg   <= '0;
            row_last_reg  <= '0;
            out_last_reg  <= '0;
            excl_reg      <= 1'b0;
            rev_reg       <= 1'b0;
            etype_reg     <= ELEM_INT32;
            slab_size_reg <= INDEX_WIDTH'(1);
        end
        else
        begin
            in_last_reg   <= in_last_next;
            row_last_reg  <= row_last_next;
            out_last_reg  <= out_last_next;
            excl_reg      <= excl_next;
            rev_reg       <= rev_next;
            etype_reg     <= etype_next;
            slab_size_reg <= slab_size_next;
        end
    end

    assign cfg.in_last        = in_last_reg;
    assign cfg.row_last       = row_last_reg;
    assign cfg.out_last       = out_last_reg;
    assign cfg.exclusive_mode = excl_reg;
    assign cfg.reverse_mode   = rev_reg;
    assign cfg.elem_type      = etype_reg;
    assign cfg.slab_size      = slab_size_reg;

endmodule

// ----- rtl/acs_scan_ctrl.sv -----
module acs_scan_ctrl import acs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  accept,
    output scan_t scan
);

    `include "axis_cumulative_sum_core_assert.svh"

    logic [IN_IDX_W-1:0]    inner_pos_reg, inner_pos_next;
    logic [ROW_W-1:0]       row_pos_reg, row_pos_next;
    logic [ROW_W-1:0]       outer_pos_reg, outer_pos_next;
    logic [INDEX_WIDTH-1:0] slab_base_reg, slab_base_next;

    logic [IN_IDX_W-1:0] ip;
    logic [ROW_W-1:0]    rp;
    logic [ROW_W-1:0]    op;
    logic                is_last;

    always_comb
    begin
        // Positions beyond a shrunk count act as the last position.
        ip = (inner_pos_reg > cfg.in_last)  ? cfg.in_last  : inner_pos_reg;
        rp = (row_pos_reg   > cfg.row_last) ? cfg.row_last : row_pos_reg;
        op = (outer_pos_reg > cfg.out_last) ? cfg.out_last : outer_pos_reg;
        is_last = (ip == cfg.in_last) && (rp == cfg.row_last) && (op == cfg.out_last);

        scan.ip        = ip;
        scan.row       = cfg.reverse_mode ? (cfg.row_last - rp) : rp;
        scan.first_row = (rp == '0);
        scan.last      = is_last;
        scan.base_ip   = slab_base_reg + INDEX_WIDTH'(ip);

        inner_pos_next = inner_pos_reg;
        row_pos_next   = row_pos_reg;
        outer_pos_next = outer_pos_reg;
        slab_base_next = slab_base_reg;
        if (accept)
        begin
            if (is_last)
            begin
                inner_pos_next = '0;
                row_pos_next   = '0;
                outer_pos_next = '0;
                slab_base_next = '0;
            end
            else if (ip != cfg.in_last)
            begin
                inner_pos_next = ip + 1'b1;
                row_pos_next   = rp;
                outer_pos_next = op;
            end
            else if (rp != cfg.row_last)
            begin
                inner_pos_next = '0;
                row_pos_next   = rp + 1'b1;
                outer_pos_next = op;
            end
            else
            begin
                inner_pos_next = '0;
                row_pos_next   = '0;
                outer_pos_next = op + 1'b1;
                slab_base_next = slab_base_reg + cfg.slab_size;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_pos_reg <= '0;
            row_pos_reg   <= '0;
            outer_pos_reg <= '0;
            slab_base_reg <= '0;
        end
        else
        begin
            inner_pos_reg <= inner_pos_next;
            row_pos_reg   <= row_pos_next;
            outer_pos_reg <= outer_pos_next;
            slab_base_reg <= slab_base_next;
        end
    end

    `ACS_ASSERT_NEXT(a_wrap_after_last, clk, rst_n, accept && is_last,
        inner_pos_reg == '0 && row_pos_reg == '0 && outer_pos_reg == '0 && slab_base_reg == '0,
        "scan position not cleared after tensor end")

endmodule

// ----- rtl/acs_accum.sv -----
module acs_accum import acs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     rd_en,
    input  logic [IN_IDX_W-1:0]      rd_addr,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     first_row,
    input  logic                     s1_valid,
    input  logic                     wr_en,
    output logic [DATA_W-1:0]        res
);

    `include "axis_cumulative_sum_core_assert.svh"

    logic [DATA_W-1:0]   mem [MAX_INNER];
    logic [DATA_W-1:0]   rdata_reg;

    logic [IN_IDX_W-1:0] addr_s1_reg;
    logic [DATA_W-1:0]   value_s1_reg;
    logic                first_s1_reg;
    logic                fwd_reg, fwd_next;
    logic [DATA_W-1:0]   fwd_data_reg;

    logic [DATA_W-1:0]   prev;
    logic [DATA_W-1:0]   acc;

    // Back-to-back hit on the entry being written this cycle (inner count one).
    assign fwd_next = rd_en ? (s1_valid && (addr_s1_reg == rd_addr)) : fwd_reg;

    always_comb
    begin
        if (first_s1_reg)
            prev = '0;
        else if (fwd_reg)
            prev = fwd_data_reg;
        else
            prev = rdata_reg;
        acc = fit_type(prev + fit_type(value_s1_reg, cfg.elem_type), cfg.elem_type);
        res = cfg.exclusive_mode ? prev : acc;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr_s1_reg] <= acc;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            addr_s1_reg  <= rd_addr;
            value_s1_reg <= value;
            first_s1_reg <= first_row;
            fwd_data_reg <= acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else
            fwd_reg <= fwd_next;
    end

    `ACS_ASSERT_NOW(a_rmw_writeback, clk, rst_n, rd_en && s1_valid, wr_en,
        "new read accepted while held item does not write back")

endmodule

// ----- rtl/axis_cumulative_sum_core.sv -----
// Channel     Dir   Payload                           Transaction
// in_stream   in    value[31:0] signed                valid && ready
// out_stream  out   sum_out[31:0], dest_index, last   valid && ready
// cfg write   in    cfg_index[2:0], cfg_wdata[24:0]   cfg_wr_en
//
// One item per cycle sustained while the output accepts; each result is registered in
// s1, s2 and s3 in turn. The per-inner running sum is a read-modify-write around a
// memory with a registered read, bypassed from the write port when the same entry is
// hit on consecutive items. Reset clears counters and configuration; the sum memory is
// not cleared, as the first row of each slab never uses the value read from it. A
// stalled output fills the stages behind it, then input ready drops.
module axis_cumulative_sum_core import acs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    acs_in_if.sink                in_stream,
    acs_out_if.source             out_stream,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    `include "axis_cumulative_sum_core_assert.svh"

    localparam int PROD_W = ROW_W + IN_IDX_W + 1;

    cfg_t  cfg;
    scan_t scan;

    logic accept;
    logic s1_adv, s2_adv;

    logic                   s1_valid_reg;
    logic [ROW_W-1:0]       s1_row_reg;
    logic [INDEX_WIDTH-1:0] s1_base_ip_reg;
    logic                   s1_last_reg;

    logic                   s2_valid_reg;
    logic [DATA_W-1:0]      s2_sum_reg;
    logic [INDEX_WIDTH-1:0] s2_prod_reg;
    logic [INDEX_WIDTH-1:0] s2_base_ip_reg;
    logic                   s2_last_reg;

    logic                   s3_valid_reg;
    logic [DATA_W-1:0]      s3_sum_reg;
    logic [INDEX_WIDTH-1:0] s3_dest_reg;
    logic                   s3_last_reg;

    logic [DATA_W-1:0]      res;
    logic [IN_IDX_W:0]      in_cnt;
    logic [PROD_W-1:0]      row_prod;

    assign s2_adv          = s2_valid_reg && (!s3_valid_reg || out_stream.ready);
    assign s1_adv          = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign in_stream.ready = !s1_valid_reg || s1_adv;
    assign accept          = in_stream.valid && in_stream.ready;

    acs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    acs_scan_ctrl u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .scan   (scan)
    );

    acs_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .rd_en     (accept),
        .rd_addr   (scan.ip),
        .value     (in_stream.value),
        .first_row (scan.first_row),
        .s1_valid  (s1_valid_reg),
        .wr_en     (s1_adv),
        .res       (res)
    );

    assign in_cnt   = {1'b0, cfg.in_last} + 1'b1;
    assign row_prod = {{(IN_IDX_W+1){1'b0}}, s1_row_reg} * {{ROW_W{1'b0}}, in_cnt};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_stream.ready)
                s1_valid_reg <= in_stream.valid;
            if (!s2_valid_reg || s2_adv)
                s2_valid_reg <= s1_valid_reg;
            if (!s3_valid_reg || out_stream.ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg     <= scan.row;
            s1_base_ip_reg <= scan.base_ip;
            s1_last_reg    <= scan.last;
        end
        if (s1_adv)
        begin
            s2_sum_reg     <= res;
            s2_prod_reg    <= INDEX_WIDTH'(row_prod);
            s2_base_ip_reg <= s1_base_ip_reg;
            s2_last_reg    <= s1_last_reg;
        end
        if (s2_adv)
        begin
            s3_sum_reg  <= s2_sum_reg;
            s3_dest_reg <= s2_base_ip_reg + s2_prod_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    assign out_stream.valid      = s3_valid_reg;
    assign out_stream.sum_out    = s3_sum_reg;
    assign out_stream.dest_index = 32'(s3_dest_reg);
    assign out_stream.last       = s3_last_reg;

    `ACS_ASSERT_NEXT(a_out_held, clk, rst_n, s3_valid_reg && !out_stream.ready, s3_valid_reg,
        "pending result dropped while stalled")
    `ACS_ASSERT_NOW(a_s1_blocks_input, clk, rst_n, s1_valid_reg && !s1_adv, !in_stream.ready,
        "input accepted while stage one is blocked")

endmodule

// ----- tb/tb_axis_cumulative_sum_core.sv -----
`timescale 1ns / 1ps

module tb_axis_cumulative_sum_core;
    import acs_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 25'h1000000;
    localparam int RANDOM_ITEMS = 1750;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_CAP    = 200;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic [31:0]       dest;
        logic              last;
    } cumsum_result_t;

    class cumsum_scoreboard;
        logic [COUNT_W-1:0]     outer_cnt;
        logic [COUNT_W-1:0]     axis_len;
        logic [INNER_CNT_W-1:0] inner_cnt;
        logic                   excl;
        logic                   rev;
        logic [1:0]             etype;
        logic [DATA_W-1:0]      sums [MAX_INNER];
        logic [IN_IDX_W-1:0]    inner_pos;
        logic [ROW_W-1:0]       row_pos;
        logic [ROW_W-1:0]       outer_pos;
        logic [INDEX_WIDTH-1:0] slab_base;
        cumsum_result_t         expected_q [$];
        int                     mismatches;

        function new();
            outer_cnt  = 1;
            axis_len   = 1;
            inner_cnt  = 1;
            excl       = 1'b0;
            rev        = 1'b0;
            etype      = ELEM_INT32;
            inner_pos  = '0;
            row_pos    = '0;
            outer_pos  = '0;
            slab_base  = '0;
            mismatches = 0;
        endfunction

        function logic [COUNT_W-1:0] clamp(logic [COUNT_W-1:0] v, logic [COUNT_W-1:0] hi);
            if (v == 0)
                return 1;
            return (v > hi) ? hi : v;
        endfunction

        function logic [DATA_W-1:0] wrap_elem(logic [DATA_W-1:0] x);
            case (etype)
                ELEM_INT8:  return {{(DATA_W-8){x[7]}}, x[7:0]};
                ELEM_UINT8: return {{(DATA_W-8){1'b0}}, x[7:0]};
                default:    return x;
            endcase
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OUTER_COUNT:    outer_cnt = data[COUNT_W-1:0];
                CFG_AXIS_LENGTH:    axis_len  = data[COUNT_W-1:0];
                CFG_INNER_COUNT:    inner_cnt = data[INNER_CNT_W-1:0];
                CFG_EXCLUSIVE_MODE: excl      = data[0];
                CFG_REVERSE_MODE:   rev       = data[0];
                CFG_ELEM_TYPE:      etype     = data[1:0];
                default: ;
            endcase
        endfunction

        function logic [COUNT_W-1:0] cur_inner();
            return clamp(COUNT_W'(inner_cnt), MAX_INNER);
        endfunction

        // Growing the row width is only safe while no later row will read the sums.
        function bit may_grow_inner();
            return row_pos == 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(logic [DATA_W-1:0] raw);
            logic [COUNT_W-1:0]     n_in, n_row, n_out;
            logic [COUNT_W-1:0]     ip, rp, op, row;
            logic [DATA_W-1:0]      v, prev, acc;
            logic [INDEX_WIDTH-1:0] dest;
            logic                   is_last;
            cumsum_result_t         r;
            n_in  = cur_inner();
            n_row = clamp(axis_len, COUNT_MAX);
            n_out = clamp(outer_cnt, COUNT_MAX);
            ip = (inner_pos < n_in)  ? COUNT_W'(inner_pos) : n_in - 1;
            rp = (row_pos < n_row)   ? COUNT_W'(row_pos)   : n_row - 1;
            op = (outer_pos < n_out) ? COUNT_W'(outer_pos) : n_out - 1;

            v    = wrap_elem(raw);
            prev = (rp == 0) ? '0 : sums[ip[IN_IDX_W-1:0]];
            acc  = wrap_elem(prev + v);
            sums[ip[IN_IDX_W-1:0]] = acc;

            row  = rev ? (n_row - 1 - rp) : rp;
            dest = slab_base + INDEX_WIDTH'(row) * INDEX_WIDTH'(n_in) + INDEX_WIDTH'(ip);
            is_last = (ip == n_in - 1) && (rp == n_row - 1) && (op == n_out - 1);

            r.sum  = excl ? prev : acc;
            r.dest = dest[31:0];
            r.last = is_last;
            expected_q.push_back(r);

            if (is_last) begin
                inner_pos = '0;
                row_pos   = '0;
                outer_pos = '0;
                slab_base = '0;
            end
            else if (ip + 1 < n_in) begin
                inner_pos = IN_IDX_W'(ip + 1);
                row_pos   = ROW_W'(rp);
                outer_pos = ROW_W'(op);
            end
            else if (rp + 1 < n_row) begin
                inner_pos = '0;
                row_pos   = ROW_W'(rp + 1);
                outer_pos = ROW_W'(op);
            end
            else begin
                inner_pos = '0;
                row_pos   = '0;
                outer_pos = ROW_W'(op + 1);
                slab_base = slab_base + INDEX_WIDTH'(n_row) * INDEX_WIDTH'(n_in);
            end
        endfunction

        function void check_result(logic [DATA_W-1:0] sum, logic [31:0] dest, logic last);
            cumsum_result_t e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: sum=%h dest=%h last=%b", sum, dest, last);
                return;
            end
            e = expected_q.pop_front();
            if (e.sum !== sum || e.dest !== dest || e.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected sum=%h dest=%h last=%b, got sum=%h dest=%h last=%b",
                             e.sum, e.dest, e.last, sum, dest, last);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    bit                    burst_mode;
    bit                    hold_request;

    acs_in_if  in_if();
    acs_out_if out_if();

    cumsum_scoreboard sb = new();

    axis_cumulative_sum_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && in_if.valid && in_if.ready)
            sb.note_input(in_if.value);
        if (rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.sum_out, out_if.dest_index, out_if.last);
    end

    // Output back-pressure; a hold request drops ready for a long stretch at once.
    initial begin : result_sink
        int   left;
        int   r;
        logic lvl;
        out_if.ready <= 1'b0;
        left = 0;
        lvl  = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_request) begin
                lvl  = 1'b0;
                left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else if (left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    lvl  = 1'b1;
                    left = (r < 55) ? $urandom_range(1, 20) : $urandom_range(50, 200);
                end
                else begin
                    lvl  = 1'b0;
                    left = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                end
            end
            out_if.ready <= lvl;
            left--;
        end
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1:       return DATA_W'($urandom_range(0, 255));
            default: return $urandom();
        endcase
    endfunction

    // Valid stays high across back-to-back transactions; it only drops for a gap or in drain.
    task automatic send_value(input logic [DATA_W-1:0] v);
        int gap;
        gap = burst_mode ? 0 : gap_len();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= v;
        do @(posedge clk); while (!in_if.ready);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.set_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] oc, input logic [CFG_DATA_W-1:0] al,
                                input logic [CFG_DATA_W-1:0] ic, input logic [CFG_DATA_W-1:0] ex,
                                input logic [CFG_DATA_W-1:0] rv, input logic [CFG_DATA_W-1:0] et);
        write_reg(CFG_OUTER_COUNT, oc);
        write_reg(CFG_AXIS_LENGTH, al);
        write_reg(CFG_INNER_COUNT, ic);
        write_reg(CFG_EXCLUSIVE_MODE, ex);
        write_reg(CFG_REVERSE_MODE, rv);
        write_reg(CFG_ELEM_TYPE, et);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] oc, al, ic, ex, rv, et;
        longint unsigned       total;
        int                    count;
        int                    sent;

        in_if.valid <= 1'b0;
        in_if.value <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= CFG_OUTER_COUNT;
        cfg_wdata   <= '0;
        rst_n       <= 1'b0;
        burst_mode   = 1'b0;
        hold_request = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset counts: every transaction is a whole tensor.
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        drain();

        // int32 wrap on the second row
        write_config(1, 2, 2, 0, 0, ELEM_INT32);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h0000_0001);
        send_value(32'hFFFF_FFFF);
        drain();

        // int8, exclusive, reversed, two slabs
        write_config(2, 2, 2, 1, 1, ELEM_INT8);
        send_value(32'h0000_007F);
        send_value(32'hFFFF_FF80);
        send_value(32'h1234_5601);
        send_value(32'h0000_00FF);
        send_value(32'h0000_007F);
        send_value(32'h0000_0080);
        send_value(32'hABCD_EF81);
        send_value(32'h0000_007E);
        drain();

        // zero counts act as one; uint8
        write_config(0, 0, 0, 0, 1, ELEM_UINT8);
        send_value(32'hFFFF_FFFF);
        send_value(32'h0000_01FF);
        drain();

        // oversized counts clamp; type code 3 behaves as int32; index wraps
        write_config(25'h1FF_FFFF, 25'h1FF_FFFF, 25'h7FF, 0, 1, 3);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'h0000_0000);
        drain();

        // shrink mid-tensor: inner position past the new count is taken as the last one
        write_config(1, 2, 3, 1, 1, ELEM_INT32);
        send_value(32'h0000_0005);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        drain();

        // long output hold-off while the input keeps streaming
        write_config(1, 8, 8, 0, 0, ELEM_INT32);
        burst_mode   = 1'b1;
        hold_request = 1'b1;
        repeat (64) send_value(rand_value());
        drain();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       oc = 0;
                1:       oc = $urandom_range(25'h100_0000, 25'h1FF_FFFF);
                default: oc = $urandom_range(1, 4);
            endcase
            case ($urandom_range(0, 9))
                0:       al = 0;
                1:       al = $urandom_range(25'h100_0000, 25'h1FF_FFFF);
                default: al = $urandom_range(1, 8);
            endcase
            if (sb.may_grow_inner()) begin
                case ($urandom_range(0, 11))
                    0:       ic = 0;
                    1:       ic = $urandom_range(1024, 2047);
                    2:       ic = $urandom_range(17, 64);
                    default: ic = $urandom_range(1, 8);
                endcase
            end
            else
                ic = $urandom_range(1, int'(sb.cur_inner()));
            // upper bits of the narrow registers are don't-care
            ex = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom()) :
                                               CFG_DATA_W'($urandom_range(0, 1));
            rv = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom()) :
                                               CFG_DATA_W'($urandom_range(0, 1));
            et = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom()) :
                                               CFG_DATA_W'($urandom_range(0, 3));
            write_config(oc, al, ic, ex, rv, et);

            total = longint'(sb.clamp(sb.outer_cnt, COUNT_MAX)) *
                    longint'(sb.clamp(sb.axis_len, COUNT_MAX)) *
                    longint'(sb.cur_inner()) * $urandom_range(1, 3);
            if ($urandom_range(0, 4) == 0 || total > PHASE_CAP)
                count = $urandom_range(1, (total > PHASE_CAP) ? PHASE_CAP : int'(total));
            else
                count = int'(total);

            burst_mode = ($urandom_range(0, 3) == 0);
            repeat (count) send_value(rand_value());
            sent += count;
            drain();
        end

        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/acs_pkg.sv
rtl/acs_stream_if.sv
rtl/acs_cfg.sv
rtl/acs_scan_ctrl.sv
rtl/acs_accum.sv
rtl/axis_cumulative_sum_core.sv
tb/tb_axis_cumulative_sum_core.sv
